// ----- src/assert_macros.svh -----
// Assertion helpers; all use the enclosing module's clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IRI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IRI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/iri_pkg.sv -----
package iri_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COORD_BITS  = 7;
	localparam int CH_BITS     = 2;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 8;

	// image bounds the store and the coordinate ports are sized for
	localparam int MAX_WIDTH    = 128;
	localparam int MAX_HEIGHT   = 128;
	localparam int MAX_CHANNELS = 3;

	// command codes
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// interpolation modes
	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_INTERP_MODE   = 3'd5;

	localparam logic [31:0] HALF_Q16 = 32'h0000_8000;
	localparam logic [16:0] ONE_Q16  = 17'h1_0000;

endpackage

// ----- src/image_resize_interpolator.sv -----
// Channel   Handshake                    Payload
// input     start / busy                 command, pixel_col, pixel_row, channel, sample_in
// result    done (one-cycle strobe)      sample_out
// config    cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A write beat leaves busy low, so the next beat may follow at once.
// A request beat raises done once it has passed through the two bit-serial
// coordinate dividers (x and y run side by side), a state to split and clamp coordinates,
// and four sample reads from the sample store and the shared 32x17 multiplier.
// arst_n resets control and config; datapath and sample store are not cleared.
// done cannot be stalled; busy drops with it, so the next beat is taken as done ends.
`include "assert_macros.svh"

module image_resize_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [iri_pkg::COORD_BITS-1:0]       pixel_col,
	input  logic [iri_pkg::COORD_BITS-1:0]       pixel_row,
	input  logic [iri_pkg::CH_BITS-1:0]          channel,
	input  logic [iri_pkg::SAMPLE_BITS-1:0]      sample_in,
	output logic                                 done,
	output logic [iri_pkg::SAMPLE_BITS-1:0]      sample_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iri_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [iri_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import iri_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_COORD, ST_CALC} state_t;

	state_t state_q;
	logic   busy_q, done_q;
	logic [SAMPLE_BITS-1:0] sample_out_q;
	logic [4:0] div_cnt_q;
	logic [3:0] cnt_q;

	// configuration registers, raw
	logic [7:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [1:0] ch_count_q;
	logic       mode_q;

	// effective sizes
	logic [7:0] sw, sh, dw, dh;
	logic [1:0] nc;

	always_comb begin
		sw = (src_w_q == 8'd0) ? 8'd1 : src_w_q;
		if (32'(src_w_q) > MAX_WIDTH) sw = 8'(MAX_WIDTH);
		sh = (src_h_q == 8'd0) ? 8'd1 : src_h_q;
		if (32'(src_h_q) > MAX_HEIGHT) sh = 8'(MAX_HEIGHT);
		nc = (ch_count_q == 2'd0) ? 2'd1 : ch_count_q;
		if (32'(ch_count_q) > MAX_CHANNELS) nc = 2'(MAX_CHANNELS);
		dw = (dst_w_q == 8'd0) ? 8'd1 : dst_w_q;
		dh = (dst_h_q == 8'd0) ? 8'd1 : dst_h_q;
	end

	logic accept, cfg_we, wr_en, req_en;
	assign accept = start && !busy_q;
	assign cfg_ready = !busy_q;
	assign cfg_we = cfg_valid && cfg_ready;
	assign wr_en  = accept && (command == CMD_WRITE) && ({1'b0, pixel_col} < sw)
		&& ({1'b0, pixel_row} < sh) && (channel < nc);
	assign req_en = accept && (command == CMD_REQUEST);

	function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y,
		input logic [1:0] c);
		int v;
		v = (int'(c) * MAX_HEIGHT + int'(y)) * MAX_WIDTH + int'(x);
		return AW'(v);
	endfunction

	function automatic logic [7:0] clamp_coord(input logic signed [17:0] v,
		input logic [7:0] size);
		if (v < 0) return 8'd0;
		if (v >= $signed({10'b0, size})) return size - 8'd1;
		return v[7:0];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= 8'd128;
			src_h_q    <= 8'd128;
			dst_w_q    <= 8'd128;
			dst_h_q    <= 8'd128;
			ch_count_q <= 2'd3;
			mode_q     <= MODE_BILINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:     src_w_q    <= cfg_data;
				REG_SRC_HEIGHT:    src_h_q    <= cfg_data;
				REG_DST_WIDTH:     dst_w_q    <= cfg_data;
				REG_DST_HEIGHT:    dst_h_q    <= cfg_data;
				REG_CHANNEL_COUNT: ch_count_q <= cfg_data[1:0];
				REG_INTERP_MODE:   mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request datapath registers
	logic [1:0]  ch_q;
	logic [31:0] dq_x_q, dq_y_q;
	logic [8:0]  rem_x_q, rem_y_q, den_x_q, den_y_q;
	logic [7:0]  x0_q, x1_q, y0_q, y1_q;
	logic [15:0] l_q, m_q;
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic [48:0] prod_q, sum_q;
	logic [31:0] acc_l_q, acc_r_q;

	// one restoring-division step for each axis
	logic [9:0] tx, ty;
	logic       gex, gey;
	always_comb begin
		tx  = {rem_x_q, dq_x_q[31]};
		ty  = {rem_y_q, dq_y_q[31]};
		gex = tx >= {1'b0, den_x_q};
		gey = ty >= {1'b0, den_y_q};
	end

	// split Q16 positions into base, fraction and nearest index
	logic signed [17:0] bx, by, nx, ny;
	logic [15:0] lx, ly;
	logic [31:0] px, py;
	always_comb begin
		px = dq_x_q - HALF_Q16;
		py = dq_y_q - HALF_Q16;
		if (dq_x_q >= HALF_Q16) begin
			bx = $signed({2'b0, px[31:16]});
			lx = px[15:0];
			nx = $signed({2'b0, dq_x_q[31:16]});
		end else begin
			bx = -18'sd1;
			lx = dq_x_q[15:0] + 16'h8000;
			nx = (dq_x_q == 32'd0) ? -18'sd1 : 18'sd0;
		end
		if (dq_y_q >= HALF_Q16) begin
			by = $signed({2'b0, py[31:16]});
			ly = py[15:0];
			ny = $signed({2'b0, dq_y_q[31:16]});
		end else begin
			by = -18'sd1;
			ly = dq_y_q[15:0] + 16'h8000;
			ny = (dq_y_q == 32'd0) ? -18'sd1 : 18'sd0;
		end
	end

	// read address: tag 0 top-left, 1 bottom-left, 2 top-right, 3 bottom-right
	logic [1:0]    rd_tag, mul_tag;
	logic [AW-1:0] rd_addr, wr_addr;
	assign rd_tag  = cnt_q[1:0];
	assign mul_tag = 2'(cnt_q - 4'd1);
	assign rd_addr = addr_of(rd_tag[1] ? x1_q : x0_q, rd_tag[0] ? y1_q : y0_q, ch_q);
	assign wr_addr = addr_of({1'b0, pixel_col}, {1'b0, pixel_row}, channel);

	// shared multiplier operands
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	always_comb begin
		mul_a = {{(32-SAMPLE_BITS){1'b0}}, rdata_q};
		mul_b = mul_tag[0] ? {1'b0, m_q} : (ONE_Q16 - {1'b0, m_q});
		if (cnt_q == 4'd6) begin
			mul_a = acc_l_q;
			mul_b = ONE_Q16 - {1'b0, l_q};
		end else if (cnt_q == 4'd7) begin
			mul_a = acc_r_q;
			mul_b = {1'b0, l_q};
		end
	end

	logic [48:0] total;
	assign total = sum_q + prod_q + 49'h0_8000_0000;

	// sample store
	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= sample_in;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req_en) begin
			ch_q    <= (channel >= nc) ? nc - 2'd1 : channel;
			dq_x_q  <= {{8'd0, pixel_col, 1'b1} * {8'd0, sw}, 16'h0};
			dq_y_q  <= {{8'd0, pixel_row, 1'b1} * {8'd0, sh}, 16'h0};
			rem_x_q <= 9'd0;
			rem_y_q <= 9'd0;
			den_x_q <= {dw, 1'b0};
			den_y_q <= {dh, 1'b0};
		end
		if (state_q == ST_DIV) begin
			rem_x_q <= gex ? 9'(tx - {1'b0, den_x_q}) : tx[8:0];
			rem_y_q <= gey ? 9'(ty - {1'b0, den_y_q}) : ty[8:0];
			dq_x_q  <= {dq_x_q[30:0], gex};
			dq_y_q  <= {dq_y_q[30:0], gey};
		end
		if (state_q == ST_COORD) begin
			if (mode_q == MODE_NEAREST) begin
				x0_q <= clamp_coord(nx, sw);
				x1_q <= clamp_coord(nx, sw);
				y0_q <= clamp_coord(ny, sh);
				y1_q <= clamp_coord(ny, sh);
				l_q  <= 16'd0;
				m_q  <= 16'd0;
			end else begin
				x0_q <= clamp_coord(bx, sw);
				x1_q <= clamp_coord(bx + 18'sd1, sw);
				y0_q <= clamp_coord(by, sh);
				y1_q <= clamp_coord(by + 18'sd1, sh);
				l_q  <= lx;
				m_q  <= ly;
			end
		end
		if (state_q == ST_CALC) begin
			prod_q <= mul_a * mul_b;
			unique case (cnt_q)
				4'd2: acc_l_q <= prod_q[31:0];
				4'd3: acc_l_q <= acc_l_q + prod_q[31:0];
				4'd4: acc_r_q <= prod_q[31:0];
				4'd5: acc_r_q <= acc_r_q + prod_q[31:0];
				4'd7: sum_q   <= prod_q;
				default: ;
			endcase
		end
	end

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			sample_out_q <= '0;
			div_cnt_q    <= 5'd0;
			cnt_q        <= 4'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_en) begin
						state_q   <= ST_DIV;
						busy_q    <= 1'b1;
						div_cnt_q <= 5'd31;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_cnt_q == 5'd0) state_q <= ST_COORD;
				end
				ST_COORD: begin
					state_q <= ST_CALC;
					cnt_q   <= 4'd0;
				end
				ST_CALC: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) begin
						// drop the 32 fraction bits, rounding half up
						sample_out_q <= total[48] ? '1 : total[47:32];
						done_q       <= 1'b1;
						busy_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign sample_out = sample_out_q;

	`IRI_ASSERT_NOW(a_busy_state, 1'b1, busy_q == (state_q != ST_IDLE), "busy out of step")
	`IRI_ASSERT_NOW(a_done_idle, done_q, !busy_q && $past(busy_q), "done without request")
	`IRI_ASSERT_NEXT(a_write_free, accept && command == CMD_WRITE, !busy_q,
		"write beat raised busy")
	`IRI_ASSERT_NEXT(a_req_busy, req_en, busy_q && state_q == ST_DIV, "request not started")
endmodule
